>>> sv/rpmg_pkg.sv
// rpmg_pkg: types, constants and codes of the randomised prim maze generator
// depends on nothing
package rpmg_pkg;

  localparam int MaxSide   = 32;
  localparam int ListDepth = 1024;
  localparam int SideW     = $clog2(MaxSide);
  localparam int MapW      = 2 * SideW;
  localparam int ListW     = $clog2(ListDepth);
  localparam int CntW      = ListW + 1;
  localparam int RndW      = 31;
  localparam int DimW      = 6;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic [1:0]      operation;
    logic [RndW-1:0] random_value;
    logic [4:0]      cell_x;
    logic [4:0]      cell_y;
  } in_word_t;

  typedef struct packed {
    logic        cell_is_wall;
    logic        carved;
    logic [4:0]  wall_x;
    logic [4:0]  wall_y;
    logic [4:0]  target_x;
    logic [4:0]  target_y;
    logic [10:0] frontier_left;
    logic        finished;
  } out_word_t;

  typedef struct packed {
    logic [SideW-1:0] x;
    logic [SideW-1:0] y;
    dir_e             dir;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILL,
    ST_START_OPEN,
    ST_NB_RD,
    ST_NB_CHK,
    ST_MOD,
    ST_ENT_RD,
    ST_ENT_WAIT,
    ST_TGT_RD,
    ST_TGT_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_READ_RD,
    ST_READ_CHK,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic fill_clr;
    logic fill_step;
    logic start_open;
    logic nb_clr;
    logic nb_rd;
    logic nb_chk;
    logic nb_next;
    logic mod_init;
    logic mod_step;
    logic ent_rd;
    logic ent_lat;
    logic tgt_rd;
    logic tgt_chk;
    logic sh_rd;
    logic sh_wr;
    logic rd_rd;
    logic rd_chk;
    logic finish;
    logic step_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;
    logic nb_last;
    logic mod_done;
    logic carve;
    logic sh_last;
    logic list_empty;
  } sts_t;

endpackage

>>> sv/rpmg_ctrl.sv
// rpmg_ctrl: sequencer of the maze generator
// depends on rpmg_pkg
module rpmg_ctrl import rpmg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  op_e   in_op_i,
  output logic  in_stall_o,
  input  logic  out_busy_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  op_e    op_q;
  logic   empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NONE;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && in_valid_i) begin
        op_q    <= in_op_i;
        empty_q <= sts_i.list_empty;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !out_busy_i) begin
          unique case (in_op_i)
            OP_START: state_d = ST_FILL;
            OP_STEP:  state_d = sts_i.list_empty ? ST_DONE : ST_MOD;
            OP_READ:  state_d = ST_READ_RD;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_FILL:       if (sts_i.fill_last) state_d = ST_START_OPEN;
      ST_START_OPEN: state_d = ST_NB_RD;
      ST_NB_RD:      state_d = ST_NB_CHK;
      ST_NB_CHK:     state_d = sts_i.nb_last ? ST_SHIFT_RD : ST_NB_RD;
      ST_MOD:        if (sts_i.mod_done) state_d = ST_ENT_RD;
      ST_ENT_RD:     state_d = ST_ENT_WAIT;
      ST_ENT_WAIT:   state_d = ST_TGT_RD;
      ST_TGT_RD:     state_d = ST_TGT_CHK;
      ST_TGT_CHK:    state_d = sts_i.carve ? ST_NB_RD : ST_SHIFT_RD;
      ST_SHIFT_RD: begin
        if (op_q != OP_STEP || sts_i.sh_last) state_d = ST_DONE;
        else state_d = ST_SHIFT_WR;
      end
      ST_SHIFT_WR:   state_d = ST_SHIFT_RD;
      ST_READ_RD:    state_d = ST_READ_CHK;
      ST_READ_CHK:   state_d = ST_DONE;
      ST_DONE:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = !(state_q == ST_IDLE && !out_busy_i);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !out_busy_i) begin
          cmd_o.load_in  = 1'b1;
          cmd_o.fill_clr = (in_op_i == OP_START);
          cmd_o.mod_init = (in_op_i == OP_STEP);
        end
      end
      ST_FILL:       cmd_o.fill_step = 1'b1;
      ST_START_OPEN: begin
        cmd_o.start_open = 1'b1;
        cmd_o.nb_clr     = 1'b1;
      end
      ST_NB_RD:      cmd_o.nb_rd = 1'b1;
      ST_NB_CHK: begin
        cmd_o.nb_chk  = 1'b1;
        cmd_o.nb_next = 1'b1;
      end
      ST_MOD:        cmd_o.mod_step = 1'b1;
      ST_ENT_RD:     cmd_o.ent_rd = 1'b1;
      ST_ENT_WAIT:   cmd_o.ent_lat = 1'b1;
      ST_TGT_RD:     cmd_o.tgt_rd = 1'b1;
      ST_TGT_CHK: begin
        cmd_o.tgt_chk = 1'b1;
        cmd_o.nb_clr  = 1'b1;
      end
      ST_SHIFT_RD:   cmd_o.sh_rd = (op_q == OP_STEP);
      ST_SHIFT_WR:   cmd_o.sh_wr = 1'b1;
      ST_READ_RD:    cmd_o.rd_rd = 1'b1;
      ST_READ_CHK:   cmd_o.rd_chk = 1'b1;
      ST_DONE: begin
        cmd_o.finish     = 1'b1;
        cmd_o.step_empty = (op_q == OP_STEP) && empty_q;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/rpmg_dp.sv
// rpmg_dp: map memory, frontier memory, modulo unit and result register
// depends on rpmg_pkg
module rpmg_dp import rpmg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  in_word_t        in_word_i,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  logic            exit_on_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output out_word_t       out_word_o
);

  // effective dimensions
  logic [DimW-1:0] w_eff, h_eff;
  assign w_eff = (width_i  > DimW'(MaxSide)) ? DimW'(MaxSide) : width_i;
  assign h_eff = (height_i > DimW'(MaxSide)) ? DimW'(MaxSide) : height_i;

  // map memory, one bit per cell
  logic         map_mem [MaxSide*MaxSide];
  logic         map_rd_q;
  logic         map_we;
  logic [MapW-1:0] map_wa, map_ra;
  logic         map_wd;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_q <= map_mem[map_ra];
  end

  // frontier memory
  entry_t       fr_mem [ListDepth];
  entry_t       fr_rd_q;
  logic         fr_we;
  logic [ListW-1:0] fr_wa, fr_ra;
  entry_t       fr_wd;

  always_ff @(posedge clk_i) begin
    if (fr_we) fr_mem[fr_wa] <= fr_wd;
    fr_rd_q <= fr_mem[fr_ra];
  end

  in_word_t        in_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MapW-1:0] fill_q;
  logic [1:0]      nb_q;
  logic [SideW-1:0] cx_q, cy_q;
  logic [RndW-1:0]  rem_q;
  logic [4:0]       mbit_q;
  logic [CntW-1:0]  idx_q;
  entry_t           ent_q;
  logic [SideW:0]   tx_q, ty_q;
  logic             carve_q;
  logic             pvalid_q;
  entry_t           pend_q;
  logic             mapinit_q;
  logic             out_valid_q;
  out_word_t        out_q, out_d;
  logic             rd_wall_q;

  // neighbour candidate, one step in direction order right left up down
  logic signed [SideW+1:0] nx, ny;
  dir_e nd;
  always_comb begin
    nx = $signed({2'b00, cx_q});
    ny = $signed({2'b00, cy_q});
    unique case (nb_q)
      2'd0: begin nx = nx + 1; nd = DIR_RIGHT; end
      2'd1: begin nx = nx - 1; nd = DIR_LEFT;  end
      2'd2: begin ny = ny - 1; nd = DIR_UP;    end
      default: begin ny = ny + 1; nd = DIR_DOWN; end
    endcase
  end
  logic nb_in;
  assign nb_in = (nx >= 1) && (ny >= 1)
              && (nx <= $signed({2'b00, w_eff}) - 2)
              && (ny <= $signed({2'b00, h_eff}) - 2);

  // wall cell of the current carve reads stale until its deferred write lands
  logic nb_carved;
  assign nb_carved = (in_q.operation == OP_STEP)
                  && (nx == $signed({2'b00, pend_q.x}))
                  && (ny == $signed({2'b00, pend_q.y}));

  // target of chosen entry
  logic signed [SideW+1:0] px, py;
  always_comb begin
    px = $signed({2'b00, ent_q.x});
    py = $signed({2'b00, ent_q.y});
    unique case (ent_q.dir)
      DIR_DOWN:  py = py + 1;
      DIR_RIGHT: px = px + 1;
      DIR_LEFT:  px = px - 1;
      default:   py = py - 1;
    endcase
  end
  logic p_on;
  assign p_on = (px >= 0) && (py >= 0) && (px < MaxSide) && (py < MaxSide);

  // modulo: restoring, one bit per cycle
  logic [RndW:0] trial;
  assign trial = {rem_q, in_q.random_value[mbit_q]} ;
  logic [RndW+1:0] rem_sh;
  assign rem_sh = {1'b0, rem_q, 1'b0} | (RndW+2)'(in_q.random_value[mbit_q]);

  // exit cell, only used when it lies on the map
  logic [SideW-1:0] ex_x, ex_y;
  assign ex_x = SideW'(w_eff - DimW'(1));
  assign ex_y = SideW'(h_eff - DimW'(2));

  always_comb begin
    map_we = 1'b0;
    map_wa = '0;
    map_wd = 1'b0;
    map_ra = '0;
    fr_we  = 1'b0;
    fr_wa  = '0;
    fr_wd  = pend_q;
    fr_ra  = '0;
    cnt_d  = cnt_q;
    if (cmd_i.fill_step) begin
      map_we = 1'b1;
      map_wa = fill_q;
      map_wd = 1'b1;
    end
    if (cmd_i.start_open) begin
      map_we = 1'b1;
      map_wa = {SideW'(1), SideW'(1)};
    end
    if (cmd_i.nb_rd) map_ra = {ny[SideW-1:0], nx[SideW-1:0]};
    if (cmd_i.nb_chk && nb_in && map_rd_q && !nb_carved && cnt_q < CntW'(ListDepth)) begin
      fr_we = 1'b1;
      fr_wa = cnt_q[ListW-1:0];
      fr_wd = '{x: nx[SideW-1:0], y: ny[SideW-1:0], dir: nd};
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.ent_rd) fr_ra = rem_q[ListW-1:0];
    if (cmd_i.tgt_rd) map_ra = {py[SideW-1:0], px[SideW-1:0]};
    if (cmd_i.tgt_chk && p_on && map_rd_q) begin
      map_we = 1'b1;
      map_wa = {py[SideW-1:0], px[SideW-1:0]};
    end
    // exit cell opened during the first neighbour read slot of start
    if (cmd_i.nb_rd && in_q.operation == OP_START && nb_q == 2'd0 && exit_on_i) begin
      map_we = 1'b1;
      map_wa = {ex_y, ex_x};
    end
    if (cmd_i.nb_rd && pvalid_q) begin
      // second carve write (wall cell) deferred to here
      map_we = 1'b1;
      map_wa = {pend_q.y, pend_q.x};
    end
    if (cmd_i.sh_rd && !sts_o.sh_last) fr_ra = ListW'(idx_q + 1'b1);
    if (cmd_i.sh_rd && sts_o.sh_last) cnt_d = cnt_q - 1'b1;
    if (cmd_i.sh_wr) begin
      fr_we = 1'b1;
      fr_wa = idx_q[ListW-1:0];
      fr_wd = fr_rd_q;
    end
    if (cmd_i.rd_rd) map_ra = {in_q.cell_y, in_q.cell_x};
    if (cmd_i.fill_clr) cnt_d = '0;
  end

  assign sts_o.fill_last  = (fill_q == '1);
  assign sts_o.nb_last    = (nb_q == 2'd3);
  assign sts_o.mod_done   = (mbit_q == 5'd0);
  assign sts_o.carve      = p_on && map_rd_q;
  assign sts_o.sh_last    = (idx_q + 1'b1 >= cnt_q);
  assign sts_o.list_empty = (cnt_q == '0);

  // result word
  always_comb begin
    out_d = '0;
    out_d.frontier_left = 11'(cnt_q);
    out_d.finished      = (cnt_q == '0);
    if (in_q.operation == OP_READ) begin
      out_d.cell_is_wall = ({1'b0, in_q.cell_x} >= w_eff) ||
                           ({1'b0, in_q.cell_y} >= h_eff) ||
                           (mapinit_q && rd_wall_q);
    end
    if (in_q.operation == OP_STEP && !cmd_i.step_empty) begin
      out_d.carved   = carve_q;
      out_d.wall_x   = ent_q.x;
      out_d.wall_y   = ent_q.y;
      out_d.target_x = tx_q[4:0];
      out_d.target_y = ty_q[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pvalid_q    <= 1'b0;
      mapinit_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.fill_clr) mapinit_q <= 1'b1;
      if (cmd_i.tgt_chk) pvalid_q <= p_on && map_rd_q;
      else if (cmd_i.nb_rd) pvalid_q <= 1'b0;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q    <= in_word_i;
      carve_q <= 1'b0;
      rd_wall_q <= 1'b0;
    end
    if (cmd_i.fill_clr) fill_q <= '0;
    else if (cmd_i.fill_step) fill_q <= fill_q + 1'b1;
    if (cmd_i.start_open) begin
      cx_q <= SideW'(1);
      cy_q <= SideW'(1);
    end
    if (cmd_i.nb_clr) nb_q <= '0;
    else if (cmd_i.nb_next) nb_q <= nb_q + 1'b1;
    if (cmd_i.mod_init) begin
      rem_q  <= '0;
      mbit_q <= 5'(RndW - 1);
    end else if (cmd_i.mod_step) begin
      if (mbit_q != 5'd0) mbit_q <= mbit_q - 1'b1;
      if ({1'b0, trial} >= (RndW+2)'(cnt_q)) rem_q <= RndW'(rem_sh - (RndW+2)'(cnt_q));
      else rem_q <= trial[RndW-1:0];
    end
    if (cmd_i.ent_rd) idx_q <= CntW'(rem_q);
    if (cmd_i.ent_lat) ent_q <= fr_rd_q;
    if (cmd_i.tgt_chk) begin
      tx_q    <= px[SideW:0];
      ty_q    <= py[SideW:0];
      carve_q <= p_on && map_rd_q;
      pend_q  <= ent_q;
      cx_q    <= px[SideW-1:0];
      cy_q    <= py[SideW-1:0];
    end
    if (cmd_i.sh_wr) idx_q <= idx_q + 1'b1;
    if (cmd_i.rd_chk) rd_wall_q <= map_rd_q;
    if (cmd_i.finish) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> sv/rpmg_exit.sv
// rpmg_exit: tells whether the exit cell lies on the map
// depends on rpmg_pkg
module rpmg_exit import rpmg_pkg::*; (
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  output logic            on_o
);
  assign on_o = (width_i >= DimW'(1)) && (height_i >= DimW'(2));
endmodule

>>> sv/randomized_prim_maze_generator.sv
// randomized_prim_maze_generator: top level, register port, sequencer and datapath
// depends on rpmg_pkg, rpmg_exit, rpmg_ctrl, rpmg_dp
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_word_i  (in_word_t)
//  out      output     out_valid/out_stall out_word_o (out_word_t)
//  cfg      input      apb write/read      maze_width @0, maze_height @4
//
// start: fills the map, opens the start cell and queues its neighbours; step: takes
// the modulo, fetches and tests the target, queues the neighbours when it carves and
// shifts the later entries down; read: one map cell; step on an empty list or unused code: result only.
// the map is unknown after reset until the first start (reads give path).
// one word at a time; a waiting result blocks the next word.
module randomized_prim_maze_generator import rpmg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DimW-1:0] width_q, height_q;
  cmd_t cmd;
  sts_t sts;
  logic exit_on;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(21);
      height_q <= DimW'(21);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegWidth) width_q <= pwdata[DimW-1:0];
      else height_q <= pwdata[DimW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegHeight) ? 32'(height_q) : 32'(width_q);

  rpmg_exit u_exit (.width_i(width_q), .height_i(height_q), .on_o(exit_on));

  rpmg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_op_i   (op_e'(in_word_i.operation)),
    .in_stall_o,
    .out_busy_i(out_valid_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rpmg_dp u_dp (
    .clk_i, .rst_ni,
    .in_word_i,
    .width_i   (width_q),
    .height_i  (height_q),
    .exit_on_i (exit_on),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_stall_i,
    .out_valid_o,
    .out_word_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o) else $error("result not raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.finished |-> out_word_o.frontier_left == '0)
    else $error("finished with entries left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("word taken while result waits");

endmodule

>>> dv/randomized_prim_maze_generator_test.sv
// randomized_prim_maze_generator_test: self-checking bench for the prim maze generator,
// predicts every result word in a small scoreboard and compares it with the block's output
// depends on rpmg_pkg and randomized_prim_maze_generator
module randomized_prim_maze_generator_test;
  import rpmg_pkg::*;

  localparam int CycleLimit = 5000000;

  class maze_scoreboard;
    int unsigned width_reg = 21;
    int unsigned height_reg = 21;
    bit map_bits [0:MaxSide*MaxSide-1];
    entry_t frontier [$];
    out_word_t expected [$];
    int mismatches = 0;

    function int eff_dim(int unsigned v);
      return (v > MaxSide) ? MaxSide : int'(v);
    endfunction

    function bit on_map(int x, int y);
      return x >= 0 && y >= 0 && x < MaxSide && y < MaxSide;
    endfunction

    function void try_queue(int x, int y, dir_e d);
      entry_t e;
      if (x < 1 || y < 1 || x > eff_dim(width_reg) - 2 || y > eff_dim(height_reg) - 2) return;
      if (!on_map(x, y) || map_bits[y*MaxSide+x] != 1'b1) return;
      if (frontier.size() >= ListDepth) return;
      e.x = x[SideW-1:0];
      e.y = y[SideW-1:0];
      e.dir = d;
      frontier = {frontier, e};
    endfunction

    function void queue_around(int x, int y);
      try_queue(x + 1, y, DIR_RIGHT);
      try_queue(x - 1, y, DIR_LEFT);
      try_queue(x, y - 1, DIR_UP);
      try_queue(x, y + 1, DIR_DOWN);
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      int wd, ht, idx, px, py;
      entry_t e;
      r = '0;
      wd = eff_dim(width_reg);
      ht = eff_dim(height_reg);
      case (op_e'(w.operation))
        OP_START: begin
          foreach (map_bits[i]) map_bits[i] = 1'b1;
          frontier.delete();
          if (on_map(wd - 1, ht - 2)) map_bits[(ht-2)*MaxSide + wd - 1] = 1'b0;
          map_bits[MaxSide+1] = 1'b0;
          queue_around(1, 1);
        end
        OP_STEP: begin
          if (frontier.size() > 0) begin
            idx = int'(w.random_value % frontier.size());
            e = frontier[idx];
            px = e.x;
            py = e.y;
            case (e.dir)
              DIR_DOWN:  py++;
              DIR_RIGHT: px++;
              DIR_LEFT:  px--;
              default:   py--;
            endcase
            r.wall_x = e.x;
            r.wall_y = e.y;
            r.target_x = px[4:0];
            r.target_y = py[4:0];
            if (on_map(px, py) && map_bits[py*MaxSide+px] == 1'b1) begin
              map_bits[e.y*MaxSide+e.x] = 1'b0;
              map_bits[py*MaxSide+px] = 1'b0;
              r.carved = 1'b1;
              queue_around(px, py);
            end
            frontier.delete(idx);
          end
        end
        OP_READ: begin
          if (w.cell_x >= wd || w.cell_y >= ht) r.cell_is_wall = 1'b1;
          else r.cell_is_wall = map_bits[w.cell_y*MaxSide + w.cell_x];
        end
        default: ;
      endcase
      r.frontier_left = 11'(frontier.size());
      r.finished = (frontier.size() == 0);
      expected = {expected, r};
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = expected.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  maze_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int cycles = 0;
  bit maze_open = 0;

  randomized_prim_maze_generator DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[randomized_prim_maze_generator] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_word(out_word_o);
  end

  task automatic send_word(in_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  task automatic send_op(op_e op, logic [RndW-1:0] rnd, logic [4:0] x, logic [4:0] y);
    in_word_t w;
    w.operation = op;
    w.random_value = rnd;
    w.cell_x = x;
    w.cell_y = y;
    send_word(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, int unsigned value);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == 3'd0) sb.width_reg = value & 6'h3f;
    else sb.height_reg = value & 6'h3f;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_dims(int unsigned wd, int unsigned ht);
    apb_write(3'd0, wd);
    apb_write(3'd4, ht);
  endtask

  task automatic random_words(int n);
    int pick;
    logic [RndW-1:0] rnd;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      rnd = RndW'($urandom());
      if ($urandom_range(9) == 0) rnd = ($urandom_range(1)) ? '1 : '0;
      if (!maze_open || pick < 4) begin
        send_op(OP_START, rnd, 5'($urandom()), 5'($urandom()));
        maze_open = 1;
      end else if (pick < 72) begin
        send_op(OP_STEP, rnd, 5'($urandom()), 5'($urandom()));
      end else if (pick < 96) begin
        send_op(OP_READ, rnd, 5'($urandom_range(sb.eff_dim(sb.width_reg))),
                5'($urandom_range(sb.eff_dim(sb.height_reg))));
      end else if (pick < 98) begin
        send_op(OP_READ, rnd, 5'($urandom()), 5'($urandom()));
      end else begin
        send_op(OP_NONE, rnd, 5'($urandom()), 5'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, unused code, default maze, edges of the fields
    send_op(OP_READ, '0, 5'd0, 5'd0);
    send_op(OP_STEP, '1, 5'd0, 5'd0);
    send_op(OP_NONE, '1, 5'd31, 5'd31);
    send_op(OP_START, '0, 5'd0, 5'd0);
    send_op(OP_READ, '0, 5'd1, 5'd1);
    send_op(OP_READ, '0, 5'd20, 5'd19);
    send_op(OP_READ, '0, 5'd31, 5'd31);
    send_op(OP_READ, '0, 5'd20, 5'd20);
    send_op(OP_STEP, '0, 5'd0, 5'd0);
    send_op(OP_STEP, '1, 5'd0, 5'd0);
    send_op(OP_STEP, 31'h5555_5555, 5'd0, 5'd0);
    send_op(OP_READ, '0, 5'd2, 5'd1);
    send_op(OP_NONE, '0, 5'd0, 5'd0);
    set_dims(5, 5);
    send_op(OP_START, '0, 5'd0, 5'd0);
    send_op(OP_READ, '0, 5'd4, 5'd3);
    for (int i = 0; i < 4; i++) send_op(OP_STEP, RndW'($urandom()), 5'd0, 5'd0);
    set_dims(63, 63);
    send_op(OP_START, '0, 5'd0, 5'd0);
    send_op(OP_READ, '0, 5'd31, 5'd30);
    set_dims(0, 1);
    send_op(OP_START, '0, 5'd0, 5'd0);
    send_op(OP_STEP, '1, 5'd0, 5'd0);
    maze_open = 0;

    send_idle = 37;
    recv_idle = 75;
    set_dims(5, 5);
    random_words(60);
    set_dims(21, 21);
    maze_open = 0;
    random_words(120);

    send_idle = 75;
    recv_idle = 37;
    set_dims(63, 63);
    maze_open = 0;
    random_words(40);
    hold_left = 3000;
    random_words(20);
    drain();
    random_words(60);
    set_dims(13, 7);
    random_words(40);

    send_idle = 0;
    recv_idle = 0;
    set_dims(31, 31);
    maze_open = 0;
    random_words(90);
    set_dims(9, 32);
    random_words(40);
    set_dims(0, 2);
    maze_open = 0;
    random_words(20);
    set_dims(21, 21);
    maze_open = 0;
    random_words(30);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.expected.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("[randomized_prim_maze_generator] OK");
    end else begin
      $display("[randomized_prim_maze_generator] ERROR");
    end
    $finish;
  end

endmodule
